// ----- hw/rtl/sgc_pkg.sv -----
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared types, register map and reset values for the sonar gesture classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgc_pkg;

  localparam int EchoWidthDefault = 24;
  localparam int TickWidth        = 16;
  localparam int CountWidth       = 4;
  localparam int AddrWidth        = 5;
  localparam int DataWidth        = 32;

  localparam logic [TickWidth-1:0]  NearTicksReset    = 16'd466;
  localparam logic [TickWidth-1:0]  FarTicksReset     = 16'd2333;
  localparam logic [TickWidth-1:0]  MoveTicksReset    = 16'd93;
  localparam logic [TickWidth-1:0]  GarbageTicksReset = 16'd9329;
  localparam logic [CountWidth-1:0] PauseLimitReset   = 4'd3;
  localparam logic [CountWidth-1:0] ReportEveryReset  = 4'd3;
  localparam logic [CountWidth-1:0] CountMax          = 4'd15;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_HOVER   = 3'd1,
    EV_CONFIRM = 3'd2,
    EV_DOWN    = 3'd3,
    EV_UP      = 3'd4,
    EV_PAUSE   = 3'd5,
    EV_RELEASE = 3'd6,
    EV_CANCEL  = 3'd7
  } gesture_event_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CONFIRM = 2'd1,
    MODE_TRACK   = 2'd2
  } gesture_mode_t;

  typedef enum logic [2:0] {
    REG_NEAR_TICKS    = 3'd0,
    REG_FAR_TICKS     = 3'd1,
    REG_MOVE_TICKS    = 3'd2,
    REG_GARBAGE_TICKS = 3'd3,
    REG_PAUSE_LIMIT   = 3'd4,
    REG_REPORT_EVERY  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [TickWidth-1:0]  near_ticks;
    logic [TickWidth-1:0]  far_ticks;
    logic [TickWidth-1:0]  move_ticks;
    logic [TickWidth-1:0]  garbage_ticks;
    logic [CountWidth-1:0] pause_limit;
    logic [CountWidth-1:0] report_every;
  } sgc_cfg_t;

endpackage

// ----- hw/rtl/sgc_echo_if.sv -----
// ----------------------------------------------------------------------------
// sgc_echo_if
// Valid/ready channel carrying one echo width beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sgc_echo_if
  import sgc_pkg::*;
#(
  parameter int ECHO_WIDTH = EchoWidthDefault
);
  logic                  valid;
  logic                  ready;
  logic [ECHO_WIDTH-1:0] echo_ticks;

  modport source (output valid, output echo_ticks, input ready);
  modport sink   (input valid, input echo_ticks, output ready);
endinterface

// ----- hw/rtl/sgc_result_if.sv -----
// ----------------------------------------------------------------------------
// sgc_result_if
// Valid/ready channel carrying one classification result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sgc_result_if
  import sgc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [2:0]           gesture_event;
  logic                 report_valid;
  logic [TickWidth-1:0] clipped_ticks;

  modport source (output valid, output gesture_event, output report_valid,
                  output clipped_ticks, input ready);
  modport sink   (input valid, input gesture_event, input report_valid,
                  input clipped_ticks, output ready);
endinterface

// ----- hw/rtl/sonar_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// sonar_gesture_classifier: an accepted echo beat passes the input and result registers.
// Throughput 1 beat per cycle unless result.ready stalls; gesture update is compares.
// Echo beats above the garbage limit are consumed without a result beat.
// Synchronous rst clears the pipeline and gesture state and reloads config defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sonar_gesture_classifier
  import sgc_pkg::*;
#(
  parameter int ECHO_WIDTH = EchoWidthDefault
)(
  input  logic                 clk,
  input  logic                 rst,
  sgc_echo_if.sink             echo,
  sgc_result_if.source         result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  sgc_cfg_t       cfg;
  gesture_event_t res_event;

  sgc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sgc_core #(
    .ECHO_WIDTH (ECHO_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (echo.valid),
    .in_ready    (echo.ready),
    .in_echo     (echo.echo_ticks),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_event   (res_event),
    .out_report  (result.report_valid),
    .out_clipped (result.clipped_ticks)
  );

  assign result.gesture_event = 3'(res_event);

`ifndef SYNTHESIS
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.clipped_ticks <= cfg.far_ticks)
    else $error("clipped distance above far limit");

  a_report_all: assert property (@(posedge clk) disable iff (rst)
    (result.valid && cfg.report_every <= 4'd1) |-> result.report_valid)
    else $error("report flag missing with unit report period");

  a_release_far: assert property (@(posedge clk) disable iff (rst)
    (result.valid && res_event == EV_RELEASE) |-> result.clipped_ticks == cfg.far_ticks)
    else $error("release without reaching far limit");
`endif

endmodule

// ----- hw/rtl/sgc_cfg.sv -----
// ----------------------------------------------------------------------------
// sgc_cfg
// APB register file holding the classifier thresholds and counters limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgc_cfg
  import sgc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output sgc_cfg_t             cfg
);

  logic       wr_en;
  reg_index_t reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = reg_index_t'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_ticks    <= NearTicksReset;
      cfg.far_ticks     <= FarTicksReset;
      cfg.move_ticks    <= MoveTicksReset;
      cfg.garbage_ticks <= GarbageTicksReset;
      cfg.pause_limit   <= PauseLimitReset;
      cfg.report_every  <= ReportEveryReset;
    end else if (wr_en) begin
      case (reg_index)
        REG_NEAR_TICKS:    cfg.near_ticks    <= pwdata[TickWidth-1:0];
        REG_FAR_TICKS:     cfg.far_ticks     <= pwdata[TickWidth-1:0];
        REG_MOVE_TICKS:    cfg.move_ticks    <= pwdata[TickWidth-1:0];
        REG_GARBAGE_TICKS: cfg.garbage_ticks <= pwdata[TickWidth-1:0];
        REG_PAUSE_LIMIT:   cfg.pause_limit   <= pwdata[CountWidth-1:0];
        REG_REPORT_EVERY:  cfg.report_every  <= pwdata[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_NEAR_TICKS:    prdata = DataWidth'(cfg.near_ticks);
      REG_FAR_TICKS:     prdata = DataWidth'(cfg.far_ticks);
      REG_MOVE_TICKS:    prdata = DataWidth'(cfg.move_ticks);
      REG_GARBAGE_TICKS: prdata = DataWidth'(cfg.garbage_ticks);
      REG_PAUSE_LIMIT:   prdata = DataWidth'(cfg.pause_limit);
      REG_REPORT_EVERY:  prdata = DataWidth'(cfg.report_every);
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/sgc_core.sv -----
// ----------------------------------------------------------------------------
// sgc_core
// Input register, gesture state machine and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgc_core
  import sgc_pkg::*;
#(
  parameter int ECHO_WIDTH = EchoWidthDefault
)(
  input  logic                  clk,
  input  logic                  rst,
  input  sgc_cfg_t              cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ECHO_WIDTH-1:0] in_echo,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gesture_event_t        out_event,
  output logic                  out_report,
  output logic [TickWidth-1:0]  out_clipped
);

  localparam int PadWidth = ECHO_WIDTH - TickWidth;

  logic                  s1_valid;
  logic [ECHO_WIDTH-1:0] s1_echo;
  logic                  s1_advance;
  logic                  garbage;
  logic                  below_far;
  logic                  emit;
  logic [TickWidth-1:0]  clipped;
  logic                  in_range;
  logic                  at_far;
  logic                  moved_down;
  logic                  moved_up;
  logic [CountWidth:0]   report_inc;
  logic                  report_hit;

  gesture_mode_t         mode;
  gesture_mode_t         mode_next;
  logic [TickWidth-1:0]  reference_ticks;
  logic [TickWidth-1:0]  reference_ticks_next;
  logic [CountWidth-1:0] still_count;
  logic [CountWidth-1:0] still_count_next;
  logic [CountWidth-1:0] still_inc;
  logic [CountWidth-1:0] report_count;
  logic [CountWidth-1:0] report_count_next;
  gesture_event_t        event_code;

  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;

  assign garbage   = s1_echo > {{PadWidth{1'b0}}, cfg.garbage_ticks};
  assign below_far = s1_echo < {{PadWidth{1'b0}}, cfg.far_ticks};
  assign clipped   = below_far ? s1_echo[TickWidth-1:0] : cfg.far_ticks;
  assign emit      = s1_valid && s1_advance && !garbage;

  assign in_range   = (cfg.near_ticks < clipped) && (clipped < cfg.far_ticks);
  assign at_far     = clipped >= cfg.far_ticks;
  assign moved_down = {1'b0, clipped} > ({1'b0, reference_ticks} + {1'b0, cfg.move_ticks});
  assign moved_up   = {1'b0, reference_ticks} > ({1'b0, clipped} + {1'b0, cfg.move_ticks});
  assign still_inc  = (still_count == CountMax) ? still_count : still_count + 1'b1;

  assign report_inc        = {1'b0, report_count} + 1'b1;
  assign report_hit        = report_inc >= {1'b0, cfg.report_every};
  assign report_count_next = report_hit ? '0 : report_inc[CountWidth-1:0];

  always_comb begin
    case (mode)
      MODE_CONFIRM: mode_next = in_range ? MODE_TRACK : MODE_IDLE;
      MODE_TRACK:   mode_next = at_far ? MODE_IDLE : MODE_TRACK;
      default:      mode_next = in_range ? MODE_CONFIRM : MODE_IDLE;
    endcase
  end

  always_comb begin
    event_code           = EV_NONE;
    reference_ticks_next = reference_ticks;
    still_count_next     = still_count;
    case (mode)
      MODE_CONFIRM: begin
        if (in_range) begin
          event_code           = EV_CONFIRM;
          reference_ticks_next = clipped;
          still_count_next     = '0;
        end else begin
          event_code = EV_CANCEL;
        end
      end
      MODE_TRACK: begin
        if (at_far) begin
          event_code = EV_RELEASE;
        end else if (moved_down || moved_up) begin
          event_code           = moved_down ? EV_DOWN : EV_UP;
          reference_ticks_next = clipped;
          still_count_next     = '0;
        end else if (still_inc >= cfg.pause_limit) begin
          event_code       = EV_PAUSE;
          still_count_next = '0;
        end else begin
          still_count_next = still_inc;
        end
      end
      default: begin
        if (in_range) begin
          event_code = EV_HOVER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_echo <= in_echo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      reference_ticks <= '0;
      still_count     <= '0;
      report_count    <= '0;
    end else if (emit) begin
      mode            <= mode_next;
      reference_ticks <= reference_ticks_next;
      still_count     <= still_count_next;
      report_count    <= report_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid && !garbage;
    end
    if (emit) begin
      out_event   <= event_code;
      out_report  <= report_hit;
      out_clipped <= clipped;
    end
  end

endmodule
